// File: hw/rtl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("next-cycle check failed");

`endif

// File: hw/rtl/mtstk_pkg.sv
// package of constants, codes and types for the min tracking stack
`default_nettype none

package mtstk_pkg;

	localparam int DEPTH  = 256;
	localparam int DATA_W = 32;
	localparam int EXT_W  = 2;
	localparam int WORD_W = DATA_W + EXT_W;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_PEEK = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/mtstk_cell.sv
// one stack cell: holds a stored word and shifts with its neighbors
`default_nettype none

module mtstk_cell
	import mtstk_pkg::*;
(
	input  wire logic              clk,
	input  wire cell_ctl_t         ctl,
	input  wire logic [WORD_W-1:0] above,
	input  wire logic [WORD_W-1:0] below,
	output logic      [WORD_W-1:0] word
);

	logic [WORD_W-1:0] word_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			word_q <= above;
		end else if (ctl.pop) begin
			word_q <= below;
		end
	end

	assign word = word_q;

endmodule

`default_nettype wire

// File: hw/rtl/min_tracking_stack.sv
// top level of the min tracking stack: row of shifting cells plus min and count control
//
//  channel   | handshake       | fields
//  ----------+-----------------+--------------------------------------
//  command   | start / busy    | operation, value
//  result    | done (strobe)   | data, minimum, status, count
//
// one command per cycle; busy stays low
// result word appears the cycle after the command, for one cycle
// the row of cells shifts down on push and up on pop, so the top is always cell 0
// reset clears the count and the minimum; the cells need no clearing
// the receiver cannot stall; each result is taken as it is shown
`default_nettype none
`include "assert_macros.svh"

module min_tracking_stack
	import mtstk_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic              [1:0]  operation,
	input  wire logic signed [DATA_W-1:0] value,
	output logic                          done,
	output logic signed      [DATA_W-1:0] data,
	output logic signed      [DATA_W-1:0] minimum,
	output logic                   [1:0]  status,
	output logic              [CNT_W-1:0] count
);

	logic                     accept;
	op_t                      op;
	cell_ctl_t                ctl;
	logic [WORD_W-1:0]        cell_word [DEPTH];
	logic [WORD_W-1:0]        push_word;
	logic [WORD_W-1:0]        x_ext;
	logic [WORD_W-1:0]        min_ext;
	logic [WORD_W-1:0]        enc_word;
	logic [WORD_W-1:0]        restored;
	logic                     top_enc;
	logic signed [DATA_W-1:0] top_val;
	logic                     is_empty;
	logic                     is_full;

	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_d;
	logic signed [DATA_W-1:0] min_q;
	logic signed [DATA_W-1:0] min_d;
	logic signed [DATA_W-1:0] data_d;
	status_t                  status_d;

	logic                     done_q;
	logic signed [DATA_W-1:0] data_q;
	logic signed [DATA_W-1:0] minimum_q;
	status_t                  status_q;
	logic [CNT_W-1:0]         count_out_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign op     = op_t'(operation);

	// row of cells, cell 0 is the top of stack
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] above;
		logic [WORD_W-1:0] below;
		if (i == 0) begin : g_first
			assign above = push_word;
		end else begin : g_rest
			assign above = cell_word[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign below = cell_word[i];
		end else begin : g_inner
			assign below = cell_word[i+1];
		end
		mtstk_cell u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.above (above),
			.below (below),
			.word  (cell_word[i])
		);
	end

	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CNT_W'(DEPTH));

	assign x_ext    = {{EXT_W{value[DATA_W-1]}}, value};
	assign min_ext  = {{EXT_W{min_q[DATA_W-1]}}, min_q};
	assign enc_word = {x_ext[WORD_W-2:0], 1'b0} - min_ext;
	assign restored = {min_ext[WORD_W-2:0], 1'b0} - cell_word[0];
	assign top_enc  = $signed(cell_word[0]) < $signed(min_ext);
	assign top_val  = top_enc ? min_q : $signed(cell_word[0][DATA_W-1:0]);

	always_comb begin
		ctl       = '0;
		push_word = x_ext;
		count_d   = count_q;
		min_d     = min_q;
		data_d    = '0;
		status_d  = ST_OK;
		if (accept) begin
			case (op)
				OP_PUSH: begin
					if (is_full) begin
						status_d = ST_FULL;
					end else begin
						ctl.push = 1'b1;
						count_d  = count_q + 1'b1;
						if (is_empty) begin
							min_d = value;
						end else if (value < min_q) begin
							// new minimum: store the encoded word
							push_word = enc_word;
							min_d     = value;
						end
					end
				end
				OP_POP: begin
					if (is_empty) begin
						status_d = ST_EMPTY;
					end else begin
						ctl.pop = 1'b1;
						count_d = count_q - 1'b1;
						data_d  = top_val;
						if (top_enc) begin
							min_d = $signed(restored[DATA_W-1:0]);
						end
					end
				end
				OP_PEEK: begin
					if (is_empty) begin
						status_d = ST_EMPTY;
					end else begin
						data_d = top_val;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			min_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			min_q   <= min_d;
			done_q  <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q      <= data_d;
			minimum_q   <= (count_d == '0) ? '0 : min_d;
			status_q    <= status_d;
			count_out_q <= count_d;
		end
	end

	assign done    = done_q;
	assign data    = data_q;
	assign minimum = minimum_q;
	assign status  = status_q;
	assign count   = count_out_q;

	`ASSERT_NEXT(a_accept_done, clk, arst_n, accept, done)
	`ASSERT_NEXT(a_idle_no_done, clk, arst_n, !accept, !done)
	`ASSERT_IMPLIES(a_full_count, clk, arst_n, done && status == ST_FULL, count == CNT_W'(DEPTH))
	`ASSERT_IMPLIES(a_empty_result, clk, arst_n, done && status == ST_EMPTY, count == '0 && data == '0)
	`ASSERT_IMPLIES(a_empty_min, clk, arst_n, done && count == '0, minimum == '0)

endmodule

`default_nettype wire

// File: sim/min_tracking_stack_test.sv
// testbench for the min tracking stack: shadow stack predictor, random and directed commands
`timescale 1ns / 100ps

module min_tracking_stack_test;
	import mtstk_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int IDX_W = $clog2(DEPTH);
	localparam longint DATA_MAX = (longint'(1) <<< (DATA_W - 1)) - 1;
	localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
	localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic signed [DATA_W-1:0] minimum;
		logic        [1:0]        status;
		logic        [CNT_W-1:0]  count;
	} result_word_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic              [1:0]  operation;
	logic signed [DATA_W-1:0] value;
	logic                     done;
	logic signed [DATA_W-1:0] data;
	logic signed [DATA_W-1:0] minimum;
	logic              [1:0]  status;
	logic         [CNT_W-1:0] count;

	// shadow of the stack contents, kept wide enough for exact encoded words
	longint       shadow_words [DEPTH];
	int unsigned  shadow_count = 0;
	longint       shadow_min = 0;
	result_word_t awaited_words [$];
	int unsigned  mismatch_cnt = 0;
	int unsigned  cycle_cnt = 0;
	bit           steady = 1'b0;

	min_tracking_stack u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.value     (value),
		.done      (done),
		.data      (data),
		.minimum   (minimum),
		.status    (status),
		.count     (count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic result_word_t stack_step(input logic [1:0] op_code,
			input logic signed [DATA_W-1:0] val);
		result_word_t             r;
		longint                   x;
		longint                   w;
		longint                   restored;
		logic signed [DATA_W-1:0] trunc;
		bit                       enc;
		x = longint'(val);
		r = '0;
		r.status = ST_OK;
		case (op_code)
			OP_PUSH: begin
				if (shadow_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					if (shadow_count == 0) begin
						shadow_words[0] = x;
						shadow_min = x;
					end else if (x < shadow_min) begin
						shadow_words[IDX_W'(shadow_count)] = 2 * x - shadow_min;
						shadow_min = x;
					end else begin
						shadow_words[IDX_W'(shadow_count)] = x;
					end
					shadow_count++;
				end
			end
			OP_POP, OP_PEEK: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					w = shadow_words[IDX_W'(shadow_count - 1)];
					enc = (w < shadow_min) || (w > DATA_MAX);
					r.data = enc ? shadow_min[DATA_W-1:0] : w[DATA_W-1:0];
					if (op_code == OP_POP) begin
						if (enc) begin
							restored = 2 * shadow_min - w;
							trunc = restored[DATA_W-1:0];
							shadow_min = longint'(trunc);
						end
						shadow_count--;
					end
				end
			end
			default: ;
		endcase
		r.minimum = (shadow_count == 0) ? '0 : shadow_min[DATA_W-1:0];
		r.count = shadow_count[CNT_W-1:0];
		return r;
	endfunction

	function automatic int unsigned gap_length();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		logic signed [DATA_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = VAL_MAX;
			1: v = VAL_MIN;
			2: v = $urandom_range(0, 16) - 8;
			3, 4: v = DATA_W'(shadow_min + $urandom_range(0, 4) - 2);
			5: v = -$urandom_range(0, 1000);
			default: v = $urandom();
		endcase
		return v;
	endfunction

	function automatic logic [1:0] pick_op(input int unsigned push_pct);
		if ($urandom_range(0, 99) < 4)
			return OP_NOP;
		if ($urandom_range(0, 99) < push_pct)
			return OP_PUSH;
		if ($urandom_range(0, 9) < 7)
			return OP_POP;
		return OP_PEEK;
	endfunction

	task automatic send_word(input logic [1:0] op_code, input logic signed [DATA_W-1:0] val);
		int unsigned gap;
		@(negedge clk);
		start <= 1'b1;
		operation <= op_code;
		value <= val;
		do
			@(posedge clk);
		while (busy);
		awaited_words.push_back(stack_step(op_code, val));
		gap = steady ? 0 : gap_length();
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic test_directed();
		send_word(OP_PEEK, $urandom());
		send_word(OP_POP, $urandom());
		send_word(OP_NOP, $urandom());
		send_word(OP_PUSH, VAL_MAX);
		send_word(OP_PEEK, $urandom());
		// largest encoded word: minimum far below the old one
		send_word(OP_PUSH, VAL_MIN);
		send_word(OP_PEEK, $urandom());
		send_word(OP_NOP, $urandom());
		send_word(OP_PUSH, '0);
		send_word(OP_PUSH, VAL_MIN);
		send_word(OP_POP, $urandom());
		send_word(OP_POP, $urandom());
		send_word(OP_POP, $urandom());
		send_word(OP_POP, $urandom());
		send_word(OP_PUSH, -1);
		send_word(OP_PUSH, 5);
		send_word(OP_PUSH, -3);
		send_word(OP_PUSH, -3);
		repeat (5)
			send_word(OP_POP, $urandom());
	endtask

	task automatic test_fill_and_drain();
		steady = 1'b0;
		while (shadow_count < DEPTH) begin
			if ((shadow_count % 64) == 0)
				steady = ($urandom_range(0, 2) == 0);
			send_word(OP_PUSH, pick_value());
		end
		send_word(OP_PUSH, VAL_MIN);
		send_word(OP_PUSH, VAL_MAX);
		send_word(OP_PEEK, $urandom());
		while (shadow_count > 0) begin
			if ((shadow_count % 64) == 0)
				steady = ($urandom_range(0, 2) == 0);
			send_word(($urandom_range(0, 9) == 0) ? OP_PEEK : OP_POP, $urandom());
		end
		steady = 1'b0;
		send_word(OP_POP, $urandom());
		send_word(OP_PEEK, $urandom());
	endtask

	task automatic test_random_mix();
		int unsigned push_pct;
		logic [1:0]  op_code;
		repeat (16) begin
			case ($urandom_range(0, 2))
				0: push_pct = 75;
				1: push_pct = 50;
				default: push_pct = 30;
			endcase
			steady = ($urandom_range(0, 3) == 0);
			repeat (50) begin
				op_code = pick_op(push_pct);
				send_word(op_code, (op_code == OP_PUSH) ? pick_value() : $urandom());
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		start = 1'b0;
		operation = OP_PUSH;
		value = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_fill_and_drain();
		test_random_mix();
		@(negedge clk);
		start <= 1'b0;
		while (awaited_words.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	always @(posedge clk) begin : check_results
		result_word_t got;
		result_word_t want;
		if (arst_n && done) begin
			got.data = data;
			got.minimum = minimum;
			got.status = status;
			got.count = count;
			if (awaited_words.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected word: data %0d minimum %0d status %0d count %0d",
						got.data, got.minimum, got.status, got.count);
			end else begin
				want = awaited_words.pop_front();
				if (got !== want) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display({"bad word: data %0d/%0d minimum %0d/%0d ",
							"status %0d/%0d count %0d/%0d (expected/actual)"},
							want.data, got.data, want.minimum, got.minimum,
							want.status, got.status, want.count, got.count);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule
